/* hw/rtl/scm_pkg.sv */
package scm_pkg;
  localparam int MAX_ROWS = 256;
  localparam int MAX_COLS = 8;
  localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W = $clog2(STORE_DEPTH);
  localparam int ROW_W = $clog2(MAX_ROWS + 1);
  localparam int RIDX_W = $clog2(MAX_ROWS);
  localparam int COL_W = 4;
  localparam int CIDX_W = 3;
  localparam int SAMPLE_W = 16;
  localparam int SUM_W = SAMPLE_W + RIDX_W;
  localparam int MEAN_W = SUM_W + 8 + 1;
  localparam int DEV_W = SAMPLE_W + 10;
  localparam int ACC_W = 64;
  localparam int COV_W = 48;
  localparam int QUO_W = 64;
  localparam int DIV_W = ROW_W + 16;
  localparam int CFG_W = 9;

  localparam logic CFG_ROWS = 1'b0;
  localparam logic CFG_COLS = 1'b1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [SUM_W-1:0] sum_t;
  typedef logic signed [MEAN_W-1:0] mean_t;
  typedef logic signed [COV_W-1:0] cov_t;
endpackage

/* hw/rtl/scm_ram.sv */
module scm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* hw/rtl/sample_covariance_matrix.sv */
// C columns and P = C(C+1)/2 column pairs
// means: one restoring divide per column; per pair: per row two store reads,
// deviation and mac, then a divide and one write
// throughput: one matrix per load (one element per cycle) + compute + C*C entries
// reset: rst_n synchronous active low; rows=2, cols=1, sums and counters cleared
module sample_covariance_matrix (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [0:0]                   cfg_index,
  input  logic [scm_pkg::CFG_W-1:0]    cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [15:0]           in_sample_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [47:0]           out_cov_value,
  output logic [2:0]                   out_row_index,
  output logic [2:0]                   out_col_index,
  output logic                         out_last_entry
);
  import scm_pkg::*;

  localparam logic [3:0] S_LOAD = 4'd0;
  localparam logic [3:0] S_MDIV = 4'd1;
  localparam logic [3:0] S_RDA  = 4'd2;
  localparam logic [3:0] S_RDB  = 4'd3;
  localparam logic [3:0] S_MUL  = 4'd4;
  localparam logic [3:0] S_ACC  = 4'd5;
  localparam logic [3:0] S_DIV  = 4'd6;
  localparam logic [3:0] S_SAT  = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;
  localparam logic [3:0] S_OPRE = 4'd9;

  logic [3:0] state_r;
  logic [ROW_W-1:0] rows_cfg_r;
  logic [COL_W-1:0] cols_cfg_r;
  logic [ROW_W-1:0] rows_e;
  logic [COL_W-1:0] cols_e;
  logic [ADDR_W:0] cnt_r;
  logic [CIDX_W-1:0] ccol_r;
  sum_t sums_r [MAX_COLS];
  mean_t means_r [MAX_COLS];
  logic [CIDX_W-1:0] ci_r, cj_r;
  logic [RIDX_W-1:0] r_r;
  logic [ADDR_W-1:0] base_r;
  logic [ADDR_W-1:0] raddr;
  logic [SAMPLE_W-1:0] rdata;
  logic signed [DEV_W-1:0] da_r, db_r;
  logic signed [ACC_W-1:0] acc_r;
  logic [6:0] dcnt_r;
  logic [QUO_W-1:0] dq_r;
  logic [DIV_W:0] drem_r;
  logic [DIV_W-1:0] dden_r;
  logic dneg_r;
  logic [CIDX_W-1:0] oi_r, oj_r;
  logic [CIDX_W-1:0] oi_nxt, oj_nxt;
  logic [2*CIDX_W-1:0] cov_raddr;
  logic [COV_W-1:0] cov_rdata;
  cov_t cov_sat;
  logic [ADDR_W:0] total;
  logic load_xfer;
  logic [DIV_W:0] dtrial;
  logic [QUO_W-1:0] qmag;
  logic signed [QUO_W-1:0] qs;

  always_comb begin
    rows_e = rows_cfg_r;
    if (rows_cfg_r < ROW_W'(2)) rows_e = ROW_W'(2);
    if (rows_cfg_r > ROW_W'(MAX_ROWS)) rows_e = ROW_W'(MAX_ROWS);
    cols_e = cols_cfg_r;
    if (cols_cfg_r == '0) cols_e = COL_W'(1);
    if (cols_cfg_r > COL_W'(MAX_COLS)) cols_e = COL_W'(MAX_COLS);
  end

  assign total = (ADDR_W+1)'(rows_e) * (ADDR_W+1)'(cols_e);
  assign in_ready = (state_r == S_LOAD);
  assign load_xfer = in_valid && in_ready;
  assign raddr = (state_r == S_RDA) ? base_r + ADDR_W'(ci_r) : base_r + ADDR_W'(cj_r);
  assign dtrial = {drem_r[DIV_W-1:0], dq_r[QUO_W-1]};

  scm_ram #(.WIDTH(SAMPLE_W), .DEPTH(STORE_DEPTH)) u_store (
    .clk  (clk),
    .we   (load_xfer),
    .waddr(cnt_r[ADDR_W-1:0]),
    .wdata(in_sample_value),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign qmag = dq_r;
  assign qs = dneg_r ? -$signed(qmag) : $signed(qmag);

  always_comb begin
    cov_sat = cov_t'(qs);
    if (qs > $signed(QUO_W'(48'sh7FFF_FFFF_FFFF))) cov_sat = 48'sh7FFF_FFFF_FFFF;
    if (qs < -$signed(QUO_W'(48'sh7FFF_FFFF_FFFF)) - 1) cov_sat = 48'sh8000_0000_0000;
  end

  // output walk, the read address is taken from the next index so the registered read matches the entry on the port
  always_comb begin
    oi_nxt = oi_r;
    oj_nxt = oj_r;
    if (state_r == S_OUT && out_ready && !out_last_entry) begin
      if (oj_r == CIDX_W'(cols_e - 1)) begin
        oj_nxt = '0;
        oi_nxt = oi_r + 1'b1;
      end else begin
        oj_nxt = oj_r + 1'b1;
      end
    end
  end

  // only the upper triangle is stored
  assign cov_raddr = (oi_nxt <= oj_nxt) ? {oi_nxt, oj_nxt} : {oj_nxt, oi_nxt};

  scm_ram #(.WIDTH(COV_W), .DEPTH(MAX_COLS * MAX_COLS)) u_cov (
    .clk  (clk),
    .we   (state_r == S_SAT),
    .waddr({ci_r, cj_r}),
    .wdata(cov_sat),
    .raddr(cov_raddr),
    .rdata(cov_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      rows_cfg_r <= ROW_W'(2);
      cols_cfg_r <= COL_W'(1);
      cnt_r <= '0;
      ccol_r <= '0;
      for (int k = 0; k < MAX_COLS; k++) sums_r[k] <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_ROWS) rows_cfg_r <= cfg_data[ROW_W-1:0];
        else cols_cfg_r <= cfg_data[COL_W-1:0];
        cnt_r <= '0;
        ccol_r <= '0;
        for (int k = 0; k < MAX_COLS; k++) sums_r[k] <= '0;
      end else begin
        case (state_r)
          S_LOAD: begin
            if (load_xfer) begin
              sums_r[ccol_r] <= sums_r[ccol_r] + SUM_W'(in_sample_value);
              ccol_r <= (ccol_r == CIDX_W'(cols_e - 1)) ? '0 : ccol_r + 1'b1;
              cnt_r <= cnt_r + 1'b1;
              if (cnt_r + 1'b1 == total) begin
                state_r <= S_MDIV;
                ci_r <= '0;
                dcnt_r <= '0;
              end
            end
          end
          S_MDIV: begin
            // mean of column ci: sum*256/rows through the shared divider
            if (dcnt_r == '0) begin
              dneg_r <= sums_r[ci_r][SUM_W-1];
              dq_r <= QUO_W'(sums_r[ci_r][SUM_W-1] ? -sums_r[ci_r] : sums_r[ci_r]) << 8;
              drem_r <= '0;
              dden_r <= DIV_W'(rows_e);
              dcnt_r <= 7'd1;
            end else if (dcnt_r == 7'd65) begin
              means_r[ci_r] <= MEAN_W'(qs);
              dcnt_r <= '0;
              if (ci_r == CIDX_W'(cols_e - 1)) begin
                ci_r <= '0;
                cj_r <= '0;
                r_r <= '0;
                base_r <= '0;
                acc_r <= '0;
                state_r <= S_RDA;
              end else begin
                ci_r <= ci_r + 1'b1;
              end
            end else begin
              drem_r <= (dtrial >= {1'b0, dden_r}) ? dtrial - {1'b0, dden_r} : dtrial;
              dq_r <= {dq_r[QUO_W-2:0], dtrial >= {1'b0, dden_r}};
              dcnt_r <= dcnt_r + 1'b1;
            end
          end
          S_RDA: state_r <= S_RDB;
          S_RDB: begin
            da_r <= (DEV_W'($signed(rdata)) <<< 8) - DEV_W'(means_r[ci_r]);
            state_r <= S_MUL;
          end
          S_MUL: begin
            db_r <= (DEV_W'($signed(rdata)) <<< 8) - DEV_W'(means_r[cj_r]);
            state_r <= S_ACC;
          end
          S_ACC: begin
            acc_r <= acc_r + ACC_W'(da_r * db_r);
            if (r_r == RIDX_W'(rows_e - 1)) begin
              state_r <= S_DIV;
              dcnt_r <= '0;
            end else begin
              r_r <= r_r + 1'b1;
              base_r <= base_r + ADDR_W'(cols_e);
              state_r <= S_RDA;
            end
          end
          S_DIV: begin
            if (dcnt_r == '0) begin
              dneg_r <= acc_r[ACC_W-1];
              dq_r <= QUO_W'(acc_r[ACC_W-1] ? -acc_r : acc_r);
              drem_r <= '0;
              dden_r <= {DIV_W'(rows_e - 1)} << 16;
              dcnt_r <= 7'd1;
            end else if (dcnt_r == 7'd65) begin
              state_r <= S_SAT;
            end else begin
              drem_r <= (dtrial >= {1'b0, dden_r}) ? dtrial - {1'b0, dden_r} : dtrial;
              dq_r <= {dq_r[QUO_W-2:0], dtrial >= {1'b0, dden_r}};
              dcnt_r <= dcnt_r + 1'b1;
            end
          end
          S_SAT: begin
            r_r <= '0;
            base_r <= '0;
            acc_r <= '0;
            if (cj_r == CIDX_W'(cols_e - 1)) begin
              if (ci_r == CIDX_W'(cols_e - 1)) begin
                state_r <= S_OPRE;
                oi_r <= '0;
                oj_r <= '0;
              end else begin
                ci_r <= ci_r + 1'b1;
                cj_r <= ci_r + 1'b1;
                state_r <= S_RDA;
              end
            end else begin
              cj_r <= cj_r + 1'b1;
              state_r <= S_RDA;
            end
          end
          S_OPRE: state_r <= S_OUT;
          S_OUT: begin
            oi_r <= oi_nxt;
            oj_r <= oj_nxt;
            if (out_ready && out_last_entry) begin
              state_r <= S_LOAD;
              cnt_r <= '0;
              ccol_r <= '0;
              for (int k = 0; k < MAX_COLS; k++) sums_r[k] <= '0;
            end
          end
          default: state_r <= S_LOAD;
        endcase
      end
    end
  end

  assign out_valid = (state_r == S_OUT);
  assign out_cov_value = cov_rdata;
  assign out_row_index = oi_r;
  assign out_col_index = oj_r;
  assign out_last_entry = (oi_r == CIDX_W'(cols_e - 1)) && (oj_r == CIDX_W'(cols_e - 1));

  a_no_in_out: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("load and output overlap");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> cnt_r < total) else $error("element count overrun");
  a_last_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last_entry && !cfg_we |=> in_ready)
    else $error("no return to load");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready && !cfg_we |=> out_valid && $stable(out_cov_value))
    else $error("result changed under stall");
endmodule

/* sim/sample_covariance_matrix_checker.sv */
`timescale 1ns / 100ps

module sample_covariance_matrix_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [0:0]                cfg_index,
  input  logic [scm_pkg::CFG_W-1:0] cfg_data,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic signed [15:0]        in_sample_value,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic signed [47:0]        out_cov_value,
  input  logic [2:0]                out_row_index,
  input  logic [2:0]                out_col_index,
  input  logic                      out_last_entry,
  output int                        mismatches,
  output int                        pending
);
  import scm_pkg::*;

  typedef struct {
    cov_t       cov;
    logic [2:0] ri;
    logic [2:0] ci;
    logic       last;
  } cov_entry_t;

  cov_entry_t entries_q[$];

  sample_t     samples[STORE_DEPTH];
  longint      col_sums[MAX_COLS];
  int          loaded;
  logic [8:0]  rows_reg;
  logic [3:0]  cols_reg;

  function automatic int rows_eff();
    if (rows_reg < 2) return 2;
    if (rows_reg > MAX_ROWS) return MAX_ROWS;
    return rows_reg;
  endfunction

  function automatic int cols_eff();
    if (cols_reg < 1) return 1;
    if (cols_reg > MAX_COLS) return MAX_COLS;
    return cols_reg;
  endfunction

  function automatic void clear_load();
    loaded = 0;
    for (int k = 0; k < MAX_COLS; k++) col_sums[k] = 0;
  endfunction

  function automatic void load_sample(input sample_t v);
    int nr;
    int nc;
    longint means[MAX_COLS];
    cov_t cov[MAX_COLS][MAX_COLS];
    longint acc;
    longint di;
    longint dj;
    longint q;
    cov_entry_t e;
    nr = rows_eff();
    nc = cols_eff();
    if (loaded >= nr * nc) clear_load();
    samples[loaded % STORE_DEPTH] = v;
    col_sums[loaded % nc] += longint'(v);
    loaded++;
    if (loaded < nr * nc) return;
    for (int j = 0; j < nc; j++) means[j] = (col_sums[j] * 256) / longint'(nr);
    for (int i = 0; i < nc; i++) begin
      for (int j = i; j < nc; j++) begin
        acc = 0;
        for (int r = 0; r < nr; r++) begin
          di = longint'(samples[r * nc + i]) * 256 - means[i];
          dj = longint'(samples[r * nc + j]) * 256 - means[j];
          acc += di * dj;
        end
        q = acc / (longint'(nr - 1) * 65536);
        if (q > 64'sd140737488355327) q = 64'sd140737488355327;
        if (q < -64'sd140737488355328) q = -64'sd140737488355328;
        cov[i][j] = q[47:0];
        cov[j][i] = q[47:0];
      end
    end
    for (int i = 0; i < nc; i++) begin
      for (int j = 0; j < nc; j++) begin
        e.cov = cov[i][j];
        e.ri = i[2:0];
        e.ci = j[2:0];
        e.last = (i == nc - 1) && (j == nc - 1);
        entries_q.insert(entries_q.size(), e);
      end
    end
    clear_load();
  endfunction

  always @(posedge clk) begin
    cov_entry_t e;
    if (!rst_n) begin
      entries_q.delete();
      clear_load();
      rows_reg = 2;
      cols_reg = 1;
      mismatches = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_ROWS) rows_reg = cfg_data[8:0];
        else cols_reg = cfg_data[3:0];
        clear_load();
      end
      if (in_valid && in_ready) load_sample(in_sample_value);
      if (out_valid && out_ready) begin
        if (entries_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected transfer: cov=%0d (%0d,%0d) last=%0b",
                     out_cov_value, out_row_index, out_col_index, out_last_entry);
        end else begin
          e = entries_q.pop_front();
          if (e.cov !== out_cov_value || e.ri !== out_row_index ||
              e.ci !== out_col_index || e.last !== out_last_entry) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp %0d (%0d,%0d) %0b, got %0d (%0d,%0d) %0b",
                       e.cov, e.ri, e.ci, e.last, out_cov_value, out_row_index,
                       out_col_index, out_last_entry);
          end
        end
      end
    end
    pending = entries_q.size();
  end

endmodule

/* sim/sample_covariance_matrix_tb.sv */
`timescale 1ns / 100ps

module sample_covariance_matrix_tb;
  import scm_pkg::*;

  logic                clk;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [0:0]          cfg_index = CFG_ROWS;
  logic [CFG_W-1:0]    cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic signed [15:0]  in_sample_value = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic signed [47:0]  out_cov_value;
  logic [2:0]          out_row_index;
  logic [2:0]          out_col_index;
  logic                out_last_entry;

  int mismatches;
  int pending;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int sent = 0;
  int cycles = 0;
  int rows_now = 2;
  int cols_now = 1;

  sample_covariance_matrix dut (.*);

  sample_covariance_matrix_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
    cycles <= cycles + 1;
    if (cycles > 1000000) begin
      $display("sample_covariance_matrix verification failed");
      $finish;
    end
  end

  task automatic send_sample(input logic signed [15:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample_value <= v;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  // wait for every entry to drain before touching registers
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == CFG_ROWS) rows_now = (data < 2) ? 2 : (data > MAX_ROWS) ? MAX_ROWS : data;
    else cols_now = (data[3:0] < 1) ? 1 : (data[3:0] > MAX_COLS) ? MAX_COLS : data[3:0];
  endtask

  task automatic configure(input logic [8:0] r, input logic [3:0] c);
    settle();
    write_reg(CFG_ROWS, r);
    write_reg(CFG_COLS, {5'($urandom_range(31)), c});
  endtask

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return $signed(16'($urandom_range(1023)) - 16'sd512);
      default: return $signed(16'($urandom));
    endcase
  endfunction

  task automatic send_matrix();
    for (int k = 0; k < rows_now * cols_now; k++) send_sample(pick_sample());
  endtask

  initial begin
    int mode;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset setting, extremes
    send_sample(16'sh8000);
    send_sample(16'sh7fff);
    configure(9'd2, 4'd2);
    send_sample(16'sh8000);
    send_sample(16'sh7fff);
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    // write during a partial load drops it
    configure(9'd3, 4'd2);
    send_sample(16'sh1234);
    send_sample(-16'sd77);
    send_sample(16'sh0100);
    settle();
    write_reg(CFG_COLS, 9'd2);
    send_matrix();
    // out of range registers clamp
    configure(9'd0, 4'd0);
    send_sample(16'sh0000);
    send_sample(-16'sd1);
    configure(9'd1, 4'd15);
    send_matrix();
    configure(9'd511, 4'd1);
    send_matrix();

    mode = 0;
    while (sent < 420) begin
      case (mode % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
        default: begin send_idle_pct = 28; recv_stall_pct = 28; end
      endcase
      if ($urandom_range(9) == 0)
        configure(9'($urandom_range(40, 2)), 4'($urandom_range(8, 1)));
      else
        configure(9'($urandom_range(6, 2)), 4'($urandom_range(8, 1)));
      if ($urandom_range(4) == 0) begin
        repeat ($urandom_range(rows_now * cols_now - 1)) send_sample(pick_sample());
        settle();
        write_reg(CFG_ROWS, 9'(rows_now));
      end
      repeat ($urandom_range(3, 1)) send_matrix();
      mode++;
    end

    settle();
    repeat (200) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("sample_covariance_matrix verification clean");
    end else begin
      $display("sample_covariance_matrix verification failed");
    end
    $finish;
  end

endmodule
